// ===== src/lfb_pkg.sv =====
// Shared types, constants and helper functions of the LED-screen frame builder.
// Used by every module under src; depends on nothing.
package lfb_pkg;

  localparam logic [7:0] TAG_MARK   = 8'h23;
  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] DIGIT_TWO  = 8'h32;
  localparam logic [7:0] FULL_COUNT = 8'd255;
  localparam int         BODY_START = 6;
  localparam int         PHASE_COUNT = 18;

  localparam logic [1:0] CFG_HEAD_FIRST   = 2'd0;
  localparam logic [1:0] CFG_HEAD_SECOND  = 2'd1;
  localparam logic [1:0] CFG_SHOW_COMMAND = 2'd2;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       is_double;
    logic [7:0] frame_address;
    logic       last_char;
  } in_word_t;

  typedef struct packed {
    logic [9:0] position;
    logic [7:0] byte_value;
    logic       overflow;
    logic       frame_done;
  } out_word_t;

  typedef struct packed {
    logic [7:0] head_first;
    logic [7:0] head_second;
    logic [7:0] show_command;
  } cfg_t;

  // One classified character: held tag characters sent before it, the
  // character itself, tag characters flushed after it, and the header job.
  typedef struct packed {
    logic [1:0] pre_cnt;
    logic       fresh;
    logic       dbl;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] post_cnt;
    logic [7:0] digit;
    logic [1:0] color;
    logic       last;
    logic [7:0] addr;
  } cmd_t;

  typedef enum logic [4:0] {
    P_PRE_HASH      = 5'd0,
    P_PRE_HASH_CLR  = 5'd1,
    P_PRE_DIG       = 5'd2,
    P_PRE_DIG_CLR   = 5'd3,
    P_B1            = 5'd4,
    P_B2            = 5'd5,
    P_FR_CLR        = 5'd6,
    P_POST_HASH     = 5'd7,
    P_POST_HASH_CLR = 5'd8,
    P_POST_DIG      = 5'd9,
    P_POST_DIG_CLR  = 5'd10,
    P_H0            = 5'd11,
    P_H1            = 5'd12,
    P_H2            = 5'd13,
    P_H3            = 5'd14,
    P_H4            = 5'd15,
    P_H5            = 5'd16,
    P_SUM           = 5'd17
  } phase_t;

  typedef struct packed {
    logic   found;
    phase_t phase;
  } phase_pick_t;

  typedef struct packed {
    logic push;
    logic full;
    logic pop;
    logic nonempty;
  } fifo_ctl_t;

  // Which byte steps a command needs, one bit per phase.
  function automatic logic [PHASE_COUNT-1:0] present_mask(input cmd_t c);
    logic [PHASE_COUNT-1:0] m;
    m = '0;
    m[P_PRE_HASH]      = (c.pre_cnt != 2'd0);
    m[P_PRE_HASH_CLR]  = (c.pre_cnt != 2'd0);
    m[P_PRE_DIG]       = (c.pre_cnt == 2'd2);
    m[P_PRE_DIG_CLR]   = (c.pre_cnt == 2'd2);
    m[P_B1]            = c.fresh;
    m[P_B2]            = c.fresh & c.dbl;
    m[P_FR_CLR]        = c.fresh;
    m[P_POST_HASH]     = (c.post_cnt != 2'd0);
    m[P_POST_HASH_CLR] = (c.post_cnt != 2'd0);
    m[P_POST_DIG]      = (c.post_cnt == 2'd2);
    m[P_POST_DIG_CLR]  = (c.post_cnt == 2'd2);
    m[P_H0]            = c.last;
    m[P_H1]            = c.last;
    m[P_H2]            = c.last;
    m[P_H3]            = c.last;
    m[P_H4]            = c.last;
    m[P_H5]            = c.last;
    m[P_SUM]           = c.last;
    return m;
  endfunction

  // First needed phase at or after the start index.
  function automatic phase_pick_t next_phase(input logic [PHASE_COUNT-1:0] m,
                                             input logic [4:0] start);
    phase_pick_t p;
    p.found = 1'b0;
    p.phase = P_PRE_HASH;
    for (int i = 0; i < PHASE_COUNT; i++) begin
      if (!p.found && m[i] && (5'(i) >= start)) begin
        p.found = 1'b1;
        p.phase = phase_t'(5'(i));
      end
    end
    return p;
  endfunction

endpackage

// ===== src/lfb_front.sv =====
// Front end of the frame builder: accepts characters, tracks color tags and
// classifies each character into a command. Depends on lfb_pkg.
module lfb_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  lfb_pkg::in_word_t in_word,
  input  logic             fifo_full,
  output logic             push,
  output lfb_pkg::cmd_t    cmd
);

  logic [1:0] pending_count, pending_count_next;
  logic [7:0] pending_digit, pending_digit_next;
  logic [1:0] current_color, current_color_next;
  logic       accept, is_hash, is_digit;
  logic [7:0] digit_off;

  assign in_stall = fifo_full;
  assign accept   = in_valid & ~fifo_full;
  assign is_hash  = ~in_word.is_double & (in_word.first_byte == lfb_pkg::TAG_MARK);
  assign is_digit = ~in_word.is_double & (in_word.first_byte >= lfb_pkg::DIGIT_ZERO) &
                    (in_word.first_byte <= lfb_pkg::DIGIT_TWO);
  assign digit_off = pending_digit - lfb_pkg::DIGIT_ZERO;

  always_comb begin
    logic [1:0] pc;
    pc = pending_count;
    pending_digit_next = pending_digit;
    current_color_next = current_color;
    cmd = '0;
    cmd.b1   = in_word.first_byte;
    cmd.b2   = in_word.second_byte;
    cmd.dbl  = in_word.is_double;
    cmd.addr = in_word.frame_address;
    cmd.last = in_word.last_char;
    case (pending_count)
      2'd0: begin
        if (is_hash) pc = 2'd1;
        else cmd.fresh = 1'b1;
      end
      2'd1: begin
        if (is_digit) begin
          pc = 2'd2;
          pending_digit_next = in_word.first_byte;
        end else begin
          cmd.pre_cnt = 2'd1;
          if (is_hash) pc = 2'd1;
          else begin
            pc = 2'd0;
            cmd.fresh = 1'b1;
          end
        end
      end
      default: begin
        if (is_hash) begin
          current_color_next = digit_off[1:0];
          pc = 2'd0;
        end else begin
          cmd.pre_cnt = 2'd2;
          if (is_hash) pc = 2'd1;
          else begin
            pc = 2'd0;
            cmd.fresh = 1'b1;
          end
        end
      end
    endcase
    // A completed tag emits nothing, so the new color is also the color of
    // every character this word sends.
    cmd.color = current_color_next;
    cmd.digit = pending_digit_next;
    pending_count_next = pc;
    if (in_word.last_char) begin
      cmd.post_cnt       = pc;
      pending_count_next = 2'd0;
      pending_digit_next = 8'd0;
      current_color_next = 2'd0;
    end
  end

  assign push = accept & ((cmd.pre_cnt != 2'd0) | cmd.fresh | cmd.last);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count <= 2'd0;
      pending_digit <= 8'd0;
      current_color <= 2'd0;
    end else if (accept) begin
      pending_count <= pending_count_next;
      pending_digit <= pending_digit_next;
      current_color <= current_color_next;
    end
  end

endmodule

// ===== src/lfb_cmd_fifo.sv =====
// Two-entry command queue between the front end and the byte writer.
// Depends on lfb_pkg.
module lfb_cmd_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lfb_pkg::cmd_t      push_cmd,
  input  logic               pop,
  output lfb_pkg::cmd_t      head,
  output lfb_pkg::fifo_ctl_t ctl
);

  lfb_pkg::cmd_t mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign head         = mem[rd_ptr];
  assign ctl.push     = push;
  assign ctl.pop      = pop;
  assign ctl.full     = (count == 2'd2);
  assign ctl.nonempty = (count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

  assert property (@(posedge clk) disable iff (rst) !(pop && count == 2'd0))
    else $error("command queue popped while empty");
  assert property (@(posedge clk) disable iff (rst) !(push && count == 2'd2))
    else $error("command queue pushed while full");
  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("command queue count out of range");

endmodule

// ===== src/lfb_back.sv =====
// Byte writer of the frame builder: expands commands into frame byte words,
// keeps position, checksum and body count, and writes header and checksum.
// Depends on lfb_pkg.
module lfb_back #(
  parameter int FRAME_BYTES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  lfb_pkg::cfg_t      cfg,
  input  lfb_pkg::cmd_t      head,
  input  logic               fifo_nonempty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output lfb_pkg::out_word_t out_word
);

  localparam int PW = $clog2(FRAME_BYTES);
  localparam logic [PW-1:0] CSUM_SLOT = PW'(FRAME_BYTES - 1);
  localparam logic [PW-1:0] START_POS = PW'(lfb_pkg::BODY_START);

  logic [PW-1:0]      wp, wp_next;
  logic [7:0]         running_xor, running_xor_next;
  logic [7:0]         body_count, body_count_next;
  logic               overflow_seen, overflow_seen_next;
  logic               busy, busy_next;
  lfb_pkg::phase_t    phase, phase_next;
  lfb_pkg::cmd_t      cmd, cmd_next;
  logic               out_valid_next;
  lfb_pkg::out_word_t out_word_next;

  logic               advance, exec, is_body;
  logic [7:0]         body_val, hi, lo;
  logic [PW+9:0]      pos_ext;
  lfb_pkg::phase_pick_t nxt, first;

  assign advance = ~out_valid | ~out_stall;
  assign exec    = busy & advance;
  assign hi      = (body_count == lfb_pkg::FULL_COUNT) ? 8'd1 : 8'd0;
  assign lo      = (body_count == lfb_pkg::FULL_COUNT) ? 8'd0 : body_count;
  assign pos_ext = {10'd0, wp};
  assign nxt     = lfb_pkg::next_phase(lfb_pkg::present_mask(cmd), 5'(phase) + 5'd1);
  assign first   = lfb_pkg::next_phase(lfb_pkg::present_mask(head), 5'd0);

  always_comb begin
    is_body  = 1'b1;
    body_val = {6'd0, cmd.color};
    case (phase)
      lfb_pkg::P_PRE_HASH, lfb_pkg::P_POST_HASH: body_val = lfb_pkg::TAG_MARK;
      lfb_pkg::P_PRE_DIG, lfb_pkg::P_POST_DIG:   body_val = cmd.digit;
      lfb_pkg::P_B1:                             body_val = cmd.b1;
      lfb_pkg::P_B2:                             body_val = cmd.b2;
      lfb_pkg::P_PRE_HASH_CLR, lfb_pkg::P_PRE_DIG_CLR, lfb_pkg::P_FR_CLR,
      lfb_pkg::P_POST_HASH_CLR, lfb_pkg::P_POST_DIG_CLR:
        body_val = {6'd0, cmd.color};
      default: is_body = 1'b0;
    endcase
  end

  always_comb begin
    wp_next            = wp;
    running_xor_next   = running_xor;
    body_count_next    = body_count;
    overflow_seen_next = overflow_seen;
    busy_next          = busy;
    phase_next         = phase;
    cmd_next           = cmd;
    pop                = 1'b0;
    out_valid_next     = out_valid;
    out_word_next      = out_word;
    if (advance) begin
      out_valid_next = 1'b0;
      out_word_next.position   = pos_ext[9:0];
      out_word_next.byte_value = body_val;
      out_word_next.overflow   = overflow_seen;
      out_word_next.frame_done = 1'b0;
    end
    if (exec) begin
      if (is_body) begin
        if (wp < CSUM_SLOT) begin
          out_valid_next   = 1'b1;
          running_xor_next = running_xor ^ body_val;
          body_count_next  = body_count + 8'd1;
          wp_next          = wp + PW'(1);
        end else begin
          overflow_seen_next = 1'b1;
        end
      end else begin
        out_valid_next = 1'b1;
        case (phase)
          lfb_pkg::P_H0: begin
            out_word_next.position   = 10'd0;
            out_word_next.byte_value = cfg.head_first;
          end
          lfb_pkg::P_H1: begin
            out_word_next.position   = 10'd1;
            out_word_next.byte_value = cfg.head_second;
          end
          lfb_pkg::P_H2: begin
            out_word_next.position   = 10'd2;
            out_word_next.byte_value = cmd.addr;
          end
          lfb_pkg::P_H3: begin
            out_word_next.position   = 10'd3;
            out_word_next.byte_value = cfg.show_command;
          end
          lfb_pkg::P_H4: begin
            out_word_next.position   = 10'd4;
            out_word_next.byte_value = hi;
          end
          lfb_pkg::P_H5: begin
            out_word_next.position   = 10'd5;
            out_word_next.byte_value = lo;
          end
          default: begin
            // Checksum closes the frame and starts the next one afresh.
            out_word_next.byte_value = running_xor ^ cmd.addr ^ cfg.show_command ^ hi ^ lo;
            out_word_next.frame_done = 1'b1;
            wp_next            = START_POS;
            running_xor_next   = 8'd0;
            body_count_next    = 8'd0;
            overflow_seen_next = 1'b0;
          end
        endcase
      end
      if (nxt.found) begin
        phase_next = nxt.phase;
      end else if (fifo_nonempty) begin
        pop        = 1'b1;
        cmd_next   = head;
        phase_next = first.phase;
      end else begin
        busy_next = 1'b0;
      end
    end else if (!busy && fifo_nonempty) begin
      pop        = 1'b1;
      busy_next  = 1'b1;
      cmd_next   = head;
      phase_next = first.phase;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp            <= START_POS;
      running_xor   <= 8'd0;
      body_count    <= 8'd0;
      overflow_seen <= 1'b0;
      busy          <= 1'b0;
      phase         <= lfb_pkg::P_PRE_HASH;
      out_valid     <= 1'b0;
    end else begin
      wp            <= wp_next;
      running_xor   <= running_xor_next;
      body_count    <= body_count_next;
      overflow_seen <= overflow_seen_next;
      busy          <= busy_next;
      phase         <= phase_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd      <= cmd_next;
    out_word <= out_word_next;
  end

  assert property (@(posedge clk) disable iff (rst) (wp <= CSUM_SLOT) && (wp >= START_POS))
    else $error("write position left the frame body");
  assert property (@(posedge clk) disable iff (rst)
                   body_count == 8'({8'd0, wp} - (PW + 8)'(lfb_pkg::BODY_START)))
    else $error("body count out of step with write position");
  assert property (@(posedge clk) disable iff (rst)
                   (exec && phase == lfb_pkg::P_SUM) |=>
                   (wp == START_POS) && !overflow_seen && out_valid && out_word.frame_done)
    else $error("checksum did not close the frame");
  assert property (@(posedge clk) disable iff (rst)
                   (exec && is_body && wp >= CSUM_SLOT) |=> overflow_seen)
    else $error("dropped body byte not flagged");

endmodule

// ===== src/led_screen_frame_builder.sv =====
// Top level of the LED-screen frame builder: configuration registers and the
// front end, command queue and byte writer. Depends on lfb_pkg and the lfb_ modules.
//
// Use: characters, already in code-page bytes, enter as words on the input
// channel (in_valid / in_stall / in_word). Each word leaves zero or more frame
// byte writes on the output channel (out_valid / out_stall / out_word): the
// body starting at position 6, and after the word marked last_char the six
// header bytes at positions 0 to 5 and the checksum, flagged frame_done.
// The header registers are written through cfg_write / cfg_index / cfg_data;
// the user must do so only while the block is idle; the block does not enforce it.
// Flow: with the writer free, a word's first write passes the command queue,
// the writer's command register and the output register. The byte writer
// produces at most one frame byte per cycle and waits while the output stalls; a
// single-byte character writes 2 bytes, a double-byte character 3, a broken tag
// two more per held character (the character and its color byte), and the last
// word 7 more for header and checksum. Color tags write no byte. A two-word
// command queue lets the front end keep accepting while the writer is busy.
// A stalled output word holds; the writer waits and, once the queue fills,
// in_stall rises. Reset clears the registers and starts an empty frame.
module led_screen_frame_builder #(
  parameter int FRAME_BYTES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  lfb_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output lfb_pkg::out_word_t out_word,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  lfb_pkg::cfg_t      cfg;
  lfb_pkg::cmd_t      push_cmd, head;
  lfb_pkg::fifo_ctl_t fifo_ctl;
  logic               push, pop;

  // Header registers; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        lfb_pkg::CFG_HEAD_FIRST:   cfg.head_first   <= cfg_data;
        lfb_pkg::CFG_HEAD_SECOND:  cfg.head_second  <= cfg_data;
        lfb_pkg::CFG_SHOW_COMMAND: cfg.show_command <= cfg_data;
        default: ;
      endcase
    end
  end

  lfb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .fifo_full (fifo_ctl.full),
    .push      (push),
    .cmd       (push_cmd)
  );

  lfb_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .ctl      (fifo_ctl)
  );

  lfb_back #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .head          (head),
    .fifo_nonempty (fifo_ctl.nonempty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the LED-screen frame builder: directed and random
// character words, with a scoreboard class that predicts every frame byte write.
// Depends on lfb_pkg and the led_screen_frame_builder RTL.
module tb_top;

  localparam int         FRAME_SIZE   = 1024;
  localparam logic [1:0] CFG_UNUSED   = 2'd3;   // index with no register behind it
  localparam int         RANDOM_WORDS = 50;
  localparam int         DRAIN_CYCLES = 30;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         MAX_SHOWN    = 10;

  // Tracks the frame under construction and keeps the byte writes that the
  // block still owes, oldest first.
  class frame_scoreboard;
    int                 frame_bytes;
    logic [7:0]         head_first;
    logic [7:0]         head_second;
    logic [7:0]         show_cmd;
    logic [1:0]         color;
    int                 held;
    logic [7:0]         held_digit;
    int                 wr_pos;
    logic [7:0]         xor_acc;
    logic [7:0]         body_cnt;
    logic               ovf;
    lfb_pkg::out_word_t owed_writes[$];
    int                 mismatches;

    function new(int size);
      frame_bytes = size;
      head_first  = 8'h00;
      head_second = 8'h00;
      show_cmd    = 8'h00;
      mismatches  = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      color      = 2'd0;
      held       = 0;
      held_digit = 8'h00;
      wr_pos     = lfb_pkg::BODY_START;
      xor_acc    = 8'h00;
      body_cnt   = 8'h00;
      ovf        = 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] v);
      case (idx)
        lfb_pkg::CFG_HEAD_FIRST:   head_first  = v;
        lfb_pkg::CFG_HEAD_SECOND:  head_second = v;
        lfb_pkg::CFG_SHOW_COMMAND: show_cmd    = v;
        default: ;
      endcase
    endfunction

    function void push_write(int pos, logic [7:0] v, logic done);
      lfb_pkg::out_word_t e;
      e.position   = 10'(pos);
      e.byte_value = v;
      e.overflow   = ovf;
      e.frame_done = done;
      owed_writes = {owed_writes, e};
    endfunction

    // The last slot stays free for the checksum; anything past it is dropped.
    function void store_body(logic [7:0] v);
      if (wr_pos < frame_bytes - 1) begin
        push_write(wr_pos, v, 1'b0);
        xor_acc  = xor_acc ^ v;
        body_cnt = body_cnt + 8'd1;
        wr_pos++;
      end else begin
        ovf = 1'b1;
      end
    endfunction

    function void put_glyph(logic [7:0] b1, logic [7:0] b2, logic dbl);
      store_body(b1);
      if (dbl) store_body(b2);
      store_body({6'd0, color});
    endfunction

    function void start_fresh(logic [7:0] b1, logic [7:0] b2, logic dbl);
      if (!dbl && b1 == lfb_pkg::TAG_MARK) held = 1;
      else put_glyph(b1, b2, dbl);
    endfunction

    function void note_char(lfb_pkg::in_word_t w);
      logic       is_digit;
      logic [7:0] hi;
      logic [7:0] lo;
      logic [7:0] sum;
      is_digit = !w.is_double && w.first_byte >= lfb_pkg::DIGIT_ZERO &&
                 w.first_byte <= lfb_pkg::DIGIT_TWO;
      if (held == 0) begin
        start_fresh(w.first_byte, w.second_byte, w.is_double);
      end else if (held == 1) begin
        if (is_digit) begin
          held       = 2;
          held_digit = w.first_byte;
        end else begin
          held = 0;
          put_glyph(lfb_pkg::TAG_MARK, 8'h00, 1'b0);
          start_fresh(w.first_byte, w.second_byte, w.is_double);
        end
      end else begin
        if (!w.is_double && w.first_byte == lfb_pkg::TAG_MARK) begin
          color = 2'(held_digit - lfb_pkg::DIGIT_ZERO);
          held  = 0;
        end else begin
          held = 0;
          put_glyph(lfb_pkg::TAG_MARK, 8'h00, 1'b0);
          put_glyph(held_digit, 8'h00, 1'b0);
          start_fresh(w.first_byte, w.second_byte, w.is_double);
        end
      end
      if (w.last_char) begin
        if (held >= 1) put_glyph(lfb_pkg::TAG_MARK, 8'h00, 1'b0);
        if (held == 2) put_glyph(held_digit, 8'h00, 1'b0);
        held = 0;
        hi = body_cnt / lfb_pkg::FULL_COUNT;
        lo = body_cnt % lfb_pkg::FULL_COUNT;
        push_write(0, head_first, 1'b0);
        push_write(1, head_second, 1'b0);
        push_write(2, w.frame_address, 1'b0);
        push_write(3, show_cmd, 1'b0);
        push_write(4, hi, 1'b0);
        push_write(5, lo, 1'b0);
        sum = xor_acc ^ w.frame_address ^ show_cmd ^ hi ^ lo;
        push_write(wr_pos, sum, 1'b1);
        restart_frame();
      end
    endfunction

    function void check_write(lfb_pkg::out_word_t got);
      lfb_pkg::out_word_t want;
      if (owed_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: write pos %0d val %02h ovf %0b done %0b with nothing owed",
                   $time, got.position, got.byte_value, got.overflow, got.frame_done);
        return;
      end
      want = owed_writes[0];
      owed_writes.delete(0);
      if (got.position !== want.position || got.byte_value !== want.byte_value ||
          got.overflow !== want.overflow || got.frame_done !== want.frame_done) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("%0t: expected pos %0d val %02h ovf %0b done %0b", $time,
                   want.position, want.byte_value, want.overflow, want.frame_done);
          $display("%0t: actual   pos %0d val %02h ovf %0b done %0b", $time,
                   got.position, got.byte_value, got.overflow, got.frame_done);
        end
      end
    endfunction

    function int outstanding();
      return owed_writes.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  lfb_pkg::in_word_t  in_word;
  logic               out_valid;
  logic               out_stall;
  lfb_pkg::out_word_t out_word;
  logic               cfg_write;
  logic [1:0]         cfg_index;
  logic [7:0]         cfg_data;

  frame_scoreboard   sb;
  lfb_pkg::in_word_t msg_q[$];
  int                words_sent = 0;
  bit                long_hold_req = 1'b0;

  led_screen_frame_builder #(.FRAME_BYTES(FRAME_SIZE)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Both channels are sampled at the rising edge; inputs only move at the
  // falling edge, so the values seen here are settled. A word accepted now
  // cannot have a write out at the same edge, so the order of the two calls
  // does not matter.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_char(in_word);
      if (out_valid && !out_stall) sb.check_write(out_word);
    end
  end

  // Idle length: zero most of the time, then mostly short, now and then long.
  function automatic int gap_len(int busy_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r >= busy_pct) return 0;
    if (r < busy_pct / 8) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic lfb_pkg::in_word_t char_word(logic [7:0] b1, logic [7:0] b2,
                                                  logic dbl);
    lfb_pkg::in_word_t w;
    w.first_byte    = b1;
    w.second_byte   = b2;
    w.is_double     = dbl;
    w.frame_address = 8'($urandom);
    w.last_char     = 1'b0;
    return w;
  endfunction

  function automatic void add_word(lfb_pkg::in_word_t w);
    msg_q = {msg_q, w};
  endfunction

  function automatic logic [7:0] rand_digit();
    return lfb_pkg::DIGIT_ZERO + 8'($urandom_range(0, 2));
  endfunction

  function automatic void add_tag(logic [7:0] digit);
    add_word(char_word(lfb_pkg::TAG_MARK, 8'($urandom), 1'b0));
    add_word(char_word(digit, 8'($urandom), 1'b0));
    add_word(char_word(lfb_pkg::TAG_MARK, 8'($urandom), 1'b0));
  endfunction

  // Mostly plain text and complete color tags; the rest are broken or cut
  // tags and double-byte words that look like tag characters.
  function automatic void add_random_piece();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      add_word(char_word(8'($urandom), 8'($urandom), 1'b0));
    end else if (kind < 50) begin
      add_word(char_word(8'($urandom), 8'($urandom), 1'b1));
    end else if (kind < 65) begin
      add_tag(rand_digit());
    end else if (kind < 72) begin
      add_word(char_word(lfb_pkg::TAG_MARK, 8'($urandom), 1'b0));
      add_word(char_word(8'($urandom), 8'($urandom), 1'b0));
    end else if (kind < 79) begin
      add_word(char_word(lfb_pkg::TAG_MARK, 8'($urandom), 1'b0));
      add_word(char_word(rand_digit(), 8'($urandom), 1'b0));
      add_word(char_word(8'($urandom), 8'($urandom), 1'($urandom)));
    end else if (kind < 84) begin
      add_word(char_word(lfb_pkg::TAG_MARK, 8'($urandom), 1'b0));
    end else if (kind < 89) begin
      add_word(char_word(lfb_pkg::TAG_MARK, 8'($urandom), 1'b0));
      add_word(char_word(rand_digit(), 8'($urandom), 1'b0));
    end else if (kind < 94) begin
      add_word(char_word($urandom_range(0, 1) ? lfb_pkg::TAG_MARK : rand_digit(),
                         8'($urandom), 1'b1));
    end else begin
      add_word(char_word(rand_digit(), 8'($urandom), 1'b0));
    end
  endfunction

  // Offers one word and holds it until the block takes it. Valid is left
  // high so that a following word can go out back to back.
  task automatic send_word(input lfb_pkg::in_word_t w);
    @(negedge clk);
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic idle_input(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_word  <= lfb_pkg::in_word_t'(26'($urandom));
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Sends the queued message as one frame: the final word carries last_char.
  // Valid always drops after the final word. At pause_at the sender stops
  // until every owed write has come out.
  task automatic send_msg(input bit steady, input int pause_at);
    int n;
    msg_q[msg_q.size() - 1].last_char = 1'b1;
    foreach (msg_q[i]) begin
      send_word(msg_q[i]);
      if (i == pause_at) begin
        idle_input(1);
        wait_drained();
      end else begin
        n = steady ? 0 : gap_len(40);
        if (i == msg_q.size() - 1 && n == 0) n = 1;
        idle_input(n);
      end
    end
    msg_q.delete();
  endtask

  // Waits for the block to go quiet; tag words leave no write to wait on,
  // so a few extra cycles cover work that is still in flight.
  task automatic settle();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic write_all(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
    write_reg(lfb_pkg::CFG_HEAD_FIRST, a);
    write_reg(lfb_pkg::CFG_HEAD_SECOND, b);
    write_reg(lfb_pkg::CFG_SHOW_COMMAND, c);
  endtask

  // Receiver side: random stall runs, calm stretches with no stall at all,
  // and on request one long hold that backs the block up into its input.
  initial begin
    int n;
    int calm;
    out_stall = 1'b0;
    calm = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (calm > 0) begin
        calm--;
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < 2) begin
        calm = $urandom_range(40, 150);
        out_stall <= 1'b0;
      end else begin
        n = gap_len(25);
        if (n == 0) begin
          out_stall <= 1'b0;
        end else begin
          out_stall <= 1'b1;
          repeat (n - 1) @(negedge clk);
        end
      end
    end
  end

  initial begin
    lfb_pkg::in_word_t w;
    int                target;
    int                frames;
    int                pieces;
    int                pause_at;
    int                waited;
    bit                steady;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_write = 1'b0;
    cfg_index = lfb_pkg::CFG_HEAD_FIRST;
    cfg_data  = 8'h00;
    sb = new(FRAME_SIZE);
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed frame with the registers at their reset values: extreme
    // bytes, a color change, broken tags of every kind, a '#' that starts a
    // new tag, double-byte words next to tag characters, and a tag cut
    // short by the end of the message.
    add_word(char_word(8'h00, 8'hFF, 1'b0));
    add_word(char_word(8'hFF, 8'h00, 1'b0));
    add_word(char_word(8'h00, 8'hFF, 1'b1));
    add_word(char_word(8'hFF, 8'h00, 1'b1));
    add_tag(lfb_pkg::DIGIT_TWO);
    add_word(char_word(8'h41, 8'h00, 1'b0));
    add_tag(lfb_pkg::DIGIT_ZERO + 8'd1);
    add_word(char_word(lfb_pkg::TAG_MARK, 8'h00, 1'b0));
    add_word(char_word(lfb_pkg::DIGIT_TWO + 8'd1, 8'h00, 1'b0));
    add_word(char_word(lfb_pkg::TAG_MARK, 8'h00, 1'b0));
    add_word(char_word(lfb_pkg::DIGIT_TWO, 8'h00, 1'b0));
    add_word(char_word(8'h41, 8'h00, 1'b0));
    add_word(char_word(lfb_pkg::TAG_MARK, 8'h00, 1'b0));
    add_tag(lfb_pkg::DIGIT_ZERO);
    add_word(char_word(lfb_pkg::TAG_MARK, 8'h5A, 1'b1));
    add_word(char_word(lfb_pkg::TAG_MARK, 8'h00, 1'b0));
    add_word(char_word(lfb_pkg::DIGIT_ZERO, 8'hA5, 1'b1));
    add_word(char_word(lfb_pkg::TAG_MARK, 8'h00, 1'b0));
    w = char_word(lfb_pkg::DIGIT_ZERO + 8'd1, 8'h00, 1'b0);
    w.frame_address = 8'hFF;
    add_word(w);
    send_msg(1'b0, -1);

    // A message of one lone '#', flushed as text before the header.
    w = char_word(lfb_pkg::TAG_MARK, 8'hFF, 1'b0);
    w.frame_address = 8'h00;
    add_word(w);
    send_msg(1'b0, -1);

    // Exactly 255 body bytes, so the count splits as one and zero.
    settle();
    write_all(8'hFF, 8'hFF, 8'hFF);
    repeat (85) add_word(char_word(8'($urandom), 8'($urandom), 1'b1));
    send_msg(1'b1, -1);

    // Random frames, one or two per register setting. Phase one opens with
    // the long receiver hold while the sender keeps pushing; phase two has a
    // frame in which the sender waits for every owed write mid-message.
    target = words_sent + RANDOM_WORDS;
    for (int p = 0; words_sent < target || p < 3; p++) begin
      settle();
      case (p % 4)
        0:       write_all(8'h00, 8'h00, 8'h00);
        1:       write_all(8'hFF, 8'hFF, 8'hFF);
        default: write_all(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      if (p == 0) write_reg(CFG_UNUSED, 8'($urandom));
      frames = (p == 2) ? 2 : $urandom_range(1, 2);
      for (int f = 0; f < frames; f++) begin
        pieces   = $urandom_range(1, 6);
        pause_at = -1;
        steady   = ($urandom_range(0, 4) == 0);
        if (p == 1 && f == 0) begin
          long_hold_req = 1'b1;
          pieces = 12;
          steady = 1'b1;
        end else if (p == 2 && f == 1) begin
          pause_at = 2;
          pieces = 6;
        end
        repeat (pieces) add_random_piece();
        send_msg(steady, pause_at);
      end
    end

    waited = 0;
    while (sb.outstanding() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== led_screen_frame_builder.f =====
src/lfb_pkg.sv
src/lfb_front.sv
src/lfb_cmd_fifo.sv
src/lfb_back.sv
src/led_screen_frame_builder.sv
tb/sv/tb_top.sv
